### rtl/quadratic_probe_hash_insert_core_macros.svh
// Assertion macros for the quadratic probe hash insert core.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef QUADRATIC_PROBE_HASH_INSERT_CORE_MACROS_SVH
`define QUADRATIC_PROBE_HASH_INSERT_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define QPH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define QPH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/qph_pkg.sv
// Shared constants, types and state encoding for the hash insert core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package qph_pkg;

    // Table geometry (TABLE_SIZE must be a power of two)
    localparam int TABLE_SIZE     = 128;
    localparam int SLOT_W         = $clog2(TABLE_SIZE);
    localparam int MAX_PROBES     = 128;
    localparam int PROBE_W        = $clog2(MAX_PROBES + 1);
    localparam int MAX_KEY_DIGITS = 18;
    localparam int DCNT_W         = $clog2(MAX_KEY_DIGITS + 1);

    // Field widths
    localparam int DIGIT_W = 4;
    localparam int TAG_W   = 16;
    localparam int COLL_W  = 8;
    localparam int SUM_W   = 12;
    localparam int MOD_W   = 8;
    localparam int STEP_W  = $clog2(SUM_W + 1);

    localparam logic [SUM_W-1:0]  SUM_MAX        = '1;
    localparam logic [MOD_W-1:0]  HASH_MOD_RESET = 8'd127;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_HASH_MODULUS = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PROBE
    } state_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [MOD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [MOD_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [TAG_W-1:0]  tag;
        logic [COLL_W-1:0] coll;
    } tbl_wr_t;

endpackage

### rtl/qph_divider.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on qph_pkg.
`timescale 1ns / 1ps

module qph_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  qph_pkg::div_req_t req,
    output qph_pkg::div_rsp_t rsp
);
    import qph_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  dvd_reg, dvd_next;
    logic [MOD_W-1:0]  dvs_reg, dvs_next;
    logic [MOD_W-1:0]  rem_reg, rem_next;
    logic [MOD_W:0]    shifted;
    logic [MOD_W:0]    diff;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign shifted = {rem_reg, dvd_reg[SUM_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = diff[MOD_W] ? shifted[MOD_W-1:0] : diff[MOD_W-1:0];
            dvd_next  = {dvd_reg[SUM_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

### rtl/qph_table.sv
// Hash table storage: occupancy flags in flops, tag and count memories.
// Depends on qph_pkg.
`timescale 1ns / 1ps

module qph_table
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [qph_pkg::SLOT_W-1:0] rd_addr,
    output logic                      rd_occupied,
    input  qph_pkg::tbl_wr_t          wr
);
    import qph_pkg::*;

    logic [TABLE_SIZE-1:0] occ_reg;
    logic [TAG_W-1:0]      tag_mem  [TABLE_SIZE];
    logic [COLL_W-1:0]     coll_mem [TABLE_SIZE];

    // Probe the occupancy flag of the current slot
    assign rd_occupied = occ_reg[rd_addr];

    // Mark a slot taken; reset empties the table at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (wr.en)
        begin
            occ_reg[wr.addr] <= 1'b1;
        end
    end

    // Store the record payload
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            tag_mem[wr.addr]  <= wr.tag;
            coll_mem[wr.addr] <= wr.coll;
        end
    end

endmodule

### rtl/quadratic_probe_hash_insert_core.sv
// Top level of the quadratic probe hash insert core: sequencer and APB register.
// Depends on qph_pkg, qph_divider, qph_table and the assertion macro header.
`timescale 1ns / 1ps
`include "quadratic_probe_hash_insert_core_macros.svh"

// A key arrives one digit per transaction (start while busy is low). A digit
// without last_digit is absorbed and busy stays low. A last digit starts an
// insert. With a nonzero hash_modulus the bit-serial remainder unit holds the
// sequencer for its 12 shift steps, and its remainder is then loaded as the
// home slot. With hash_modulus at 0 the divide is skipped. Then one table slot
// is probed per cycle, 1 to 128 probes. The result appears on slot, collisions
// and table_full for exactly one cycle with done high; the receiver must take
// it then. busy drops in that same cycle, so a new key may start.
// hash_modulus sits at byte address 0 of the APB port and resets to 127.

module quadratic_probe_hash_insert_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qph_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [qph_pkg::APB_DATA_W-1:0] pwdata,
    output logic [qph_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    // Command side
    input  logic                           start,
    output logic                           busy,
    input  logic [qph_pkg::DIGIT_W-1:0]    key_digit,
    input  logic [qph_pkg::TAG_W-1:0]      record_tag,
    input  logic                           last_digit,
    // Result side
    output logic                           done,
    output logic [qph_pkg::SLOT_W-1:0]     slot,
    output logic [qph_pkg::COLL_W-1:0]     collisions,
    output logic                           table_full
);
    import qph_pkg::*;

    state_t              state_reg, state_next;
    logic [MOD_W-1:0]    mod_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [SLOT_W-1:0]   home_reg, home_next;
    logic [PROBE_W-1:0]  k_reg, k_next;
    logic [SLOT_W-1:0]   sq_reg, sq_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic                done_reg, done_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [COLL_W-1:0]   coll_reg, coll_next;
    logic                full_reg, full_next;

    logic                accept;
    logic                cfg_wr;
    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    sum_sat;
    logic [SUM_W-1:0]    sum_upd;
    logic [SLOT_W-1:0]   pos;
    logic                occ;
    logic                last_probe;
    logic                full_fields_ok;
    logic                coll_in_limit;
    div_req_t            div_req;
    div_rsp_t            div_rsp;
    tbl_wr_t             tbl_wr;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // APB register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_HASH_MODULUS) ? APB_DATA_W'(mod_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= HASH_MOD_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_HASH_MODULUS))
        begin
            mod_reg <= pwdata[MOD_W-1:0];
        end
    end

    // Saturating digit accumulation, capped at the key length limit
    assign sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(key_digit);
    assign sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    assign sum_upd = (cnt_reg < DCNT_W'(MAX_KEY_DIGITS)) ? sum_sat : sum_reg;

    // Alternating quadratic probe position: odd steps add, even steps subtract
    assign pos        = k_reg[0] ? (home_reg + sq_reg) : (home_reg - sq_reg);
    assign last_probe = (k_reg == PROBE_W'(MAX_PROBES - 1));

    // Remainder unit request
    assign div_req.start    = accept && last_digit && (mod_reg != '0);
    assign div_req.dividend = sum_upd;
    assign div_req.divisor  = mod_reg;

    qph_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Table write on the first free slot
    assign tbl_wr.en   = (state_reg == ST_PROBE) && !occ;
    assign tbl_wr.addr = pos;
    assign tbl_wr.tag  = tag_reg;
    assign tbl_wr.coll = COLL_W'(k_reg);

    qph_table u_table
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_addr     (pos),
        .rd_occupied (occ),
        .wr          (tbl_wr)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_digit)
                begin
                    state_next = (mod_reg == '0) ? ST_PROBE : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (!occ || last_probe)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and result outputs
    always_comb
    begin
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        home_next = home_reg;
        k_next    = k_reg;
        sq_next   = sq_reg;
        tag_next  = tag_reg;
        done_next = 1'b0;
        slot_next = slot_reg;
        coll_next = coll_reg;
        full_next = full_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (last_digit)
                    begin
                        sum_next  = '0;
                        cnt_next  = '0;
                        tag_next  = record_tag;
                        home_next = sum_upd[SLOT_W-1:0];
                        k_next    = '0;
                        sq_next   = '0;
                    end
                    else
                    begin
                        sum_next = sum_upd;
                        if (cnt_reg < DCNT_W'(MAX_KEY_DIGITS))
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    home_next = div_rsp.remainder[SLOT_W-1:0];
                end
            end
            ST_PROBE:
            begin
                if (!occ)
                begin
                    done_next = 1'b1;
                    slot_next = pos;
                    coll_next = COLL_W'(k_reg);
                    full_next = 1'b0;
                end
                else if (last_probe)
                begin
                    done_next = 1'b1;
                    slot_next = '0;
                    coll_next = COLL_W'(MAX_PROBES);
                    full_next = 1'b1;
                end
                else
                begin
                    // Step k and keep k squared modulo the table size
                    k_next  = k_reg + 1'b1;
                    sq_next = sq_reg + {k_reg[SLOT_W-2:0], 1'b1};
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        home_reg <= home_next;
        k_reg    <= k_next;
        sq_reg   <= sq_next;
        tag_reg  <= tag_next;
        slot_reg <= slot_next;
        coll_reg <= coll_next;
        full_reg <= full_next;
    end

    assign done       = done_reg;
    assign slot       = slot_reg;
    assign collisions = coll_reg;
    assign table_full = full_reg;

    // Checks
    assign full_fields_ok = (slot == '0) && (collisions == COLL_W'(MAX_PROBES));
    assign coll_in_limit  = (collisions < COLL_W'(MAX_PROBES));

    `QPH_ASSERT_NEXT(a_insert_goes_busy, accept && last_digit, busy, "insert did not raise busy")
    `QPH_ASSERT_NOW(a_done_when_idle, done, !busy, "result strobe while still busy")
    `QPH_ASSERT_NOW(a_full_result, done && table_full, full_fields_ok, "full result fields wrong")
    `QPH_ASSERT_NOW(a_found_in_limit, done && !table_full, coll_in_limit, "collisions past limit")

endmodule

### sim/qph_insert_checker.sv
// Result checker for the quadratic probe hash insert core.
// Watches the APB, command and result channels; predicts inserts with its own
// copy of the table occupancy. Depends on qph_pkg.
`timescale 1ns / 1ps

module qph_insert_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qph_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [qph_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                           pready,
    input  logic                           start,
    input  logic                           busy,
    input  logic [qph_pkg::DIGIT_W-1:0]    key_digit,
    input  logic [qph_pkg::TAG_W-1:0]      record_tag,
    input  logic                           last_digit,
    input  logic                           done,
    input  logic [qph_pkg::SLOT_W-1:0]     slot,
    input  logic [qph_pkg::COLL_W-1:0]     collisions,
    input  logic                           table_full,
    output int                             fail_count,
    output int                             pending
);
    import qph_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [COLL_W-1:0] coll;
        logic              full;
    } insert_outcome_t;

    insert_outcome_t  expected_inserts [$];
    logic [MOD_W-1:0] modulus_reg;
    logic [SUM_W-1:0] key_sum;
    int               key_digits_seen;
    logic             slot_taken [TABLE_SIZE];
    int               mismatches = 0;
    int               outstanding = 0;

    assign fail_count = mismatches;
    assign pending    = outstanding;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: insert check: %s", $time, msg);
        mismatches++;
    endtask

    // Fold one digit into the key sum; on the last digit run the probe sequence
    task place_key(input logic [DIGIT_W-1:0] digit, input logic last);
        logic [SUM_W:0]   wide_sum;
        logic [SUM_W-1:0] reduced;
        int               home;
        int               k;
        int               pos;
        int               off;
        bit               found;
        insert_outcome_t  outcome;
        if (key_digits_seen < MAX_KEY_DIGITS)
        begin
            wide_sum = key_sum + digit;
            key_sum = (wide_sum > SUM_MAX) ? SUM_MAX : wide_sum[SUM_W-1:0];
            key_digits_seen++;
        end
        if (last)
        begin
            reduced = (modulus_reg == '0) ? key_sum : key_sum % modulus_reg;
            home = int'(reduced) % TABLE_SIZE;
            key_sum = '0;
            key_digits_seen = 0;
            // Alternate +k^2 / -k^2 around home, restarting the sign per key
            found = 1'b0;
            pos = home;
            k = 0;
            while (k < MAX_PROBES && !found)
            begin
                off = k * k;
                if (k % 2 == 0)
                    off = -off;
                pos = ((home + off) % TABLE_SIZE + TABLE_SIZE) % TABLE_SIZE;
                if (!slot_taken[pos])
                    found = 1'b1;
                else
                    k++;
            end
            outcome.coll = (k > 255) ? 8'd255 : COLL_W'(k);
            if (found)
            begin
                slot_taken[pos] = 1'b1;
                outcome.slot = SLOT_W'(pos);
                outcome.full = 1'b0;
            end
            else
            begin
                outcome.slot = '0;
                outcome.full = 1'b1;
            end
            expected_inserts.push_back(outcome);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        insert_outcome_t want;
        if (!rst_n)
        begin
            expected_inserts.delete();
            modulus_reg = HASH_MOD_RESET;
            key_sum = '0;
            key_digits_seen = 0;
            foreach (slot_taken[i])
                slot_taken[i] = 1'b0;
            outstanding <= 0;
        end
        else
        begin
            // Match a result strobe against the oldest pending insert
            if (done)
            begin
                if (expected_inserts.size() == 0)
                begin
                    report_mismatch($sformatf(
                        "result slot=%0d collisions=%0d full=%0b with no insert pending",
                        slot, collisions, table_full));
                end
                else
                begin
                    want = expected_inserts.pop_front();
                    if (slot !== want.slot)
                        report_mismatch($sformatf("slot got %0d, expected %0d",
                                                  slot, want.slot));
                    if (collisions !== want.coll)
                        report_mismatch($sformatf("collisions got %0d, expected %0d",
                                                  collisions, want.coll));
                    if (table_full !== want.full)
                        report_mismatch($sformatf("table_full got %0b, expected %0b",
                                                  table_full, want.full));
                end
            end
            // Track modulus writes
            if (psel && penable && pwrite && pready && (paddr[2] == REG_HASH_MODULUS))
                modulus_reg = pwdata[MOD_W-1:0];
            // Absorb accepted digits
            if (start && !busy)
                place_key(key_digit, last_digit);
            outstanding <= expected_inserts.size();
        end
    end

endmodule

### sim/tb_quadratic_probe_hash_insert_core.sv
// Testbench top for the quadratic probe hash insert core: clock, reset,
// stimulus, watchdog and verdict. Depends on qph_pkg, the core and
// qph_insert_checker.
`timescale 1ns / 1ps

module tb_quadratic_probe_hash_insert_core;
    import qph_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 200;
    localparam int SETTLE_CYCLES  = 160;
    localparam logic [APB_ADDR_W-1:0] MODULUS_ADDR = APB_ADDR_W'(4 * REG_HASH_MODULUS);

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  start      = 1'b0;
    logic                  busy;
    logic [DIGIT_W-1:0]    key_digit  = '0;
    logic [TAG_W-1:0]      record_tag = '0;
    logic                  last_digit = 1'b0;
    logic                  done;
    logic [SLOT_W-1:0]     slot;
    logic [COLL_W-1:0]     collisions;
    logic                  table_full;

    int mismatch_total;
    int inserts_pending;
    int zero_run = 0;
    int quiet_cycles = 0;

    quadratic_probe_hash_insert_core DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .key_digit  (key_digit),
        .record_tag (record_tag),
        .last_digit (last_digit),
        .done       (done),
        .slot       (slot),
        .collisions (collisions),
        .table_full (table_full)
    );

    qph_insert_checker insert_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .key_digit  (key_digit),
        .record_tag (record_tag),
        .last_digit (last_digit),
        .done       (done),
        .slot       (slot),
        .collisions (collisions),
        .table_full (table_full),
        .fail_count (mismatch_total),
        .pending    (inserts_pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Abort when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one digit after a random gap and hold it until accepted
    task automatic send_digit(input logic [DIGIT_W-1:0] digit, input logic [TAG_W-1:0] tag,
                              input logic last);
        int gap;
        if (zero_run > 0)
        begin
            zero_run--;
            gap = 0;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            zero_run = $urandom_range(8, 40);
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 18);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        key_digit  <= digit;
        record_tag <= tag;
        last_digit <= last;
        do @(posedge clk); while (busy);
    endtask

    // Stop sending and wait until every insert has reported and the core is idle
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge clk); while (inserts_pending != 0);
        repeat (4) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // Setup and access phases; upper data bits are random noise
    task automatic write_modulus(input logic [MOD_W-1:0] modulus);
        logic [APB_DATA_W-1:0] word;
        word = $urandom();
        word[MOD_W-1:0] = modulus;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODULUS_ADDR;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly short keys of decimal digits; some overlong keys and hex digits
    task automatic send_random_key(inout int sent);
        int                 len;
        logic [DIGIT_W-1:0] digit;
        logic [TAG_W-1:0]   tag;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(19, 26) : $urandom_range(1, 8);
        tag = TAG_W'($urandom());
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                digit = DIGIT_W'($urandom_range(10, 15));
            else
                digit = DIGIT_W'($urandom_range(0, 9));
            send_digit(digit, ($urandom_range(0, 1) == 0) ? tag : TAG_W'($urandom()),
                       i == len - 1);
            sent++;
        end
    endtask

    initial
    begin
        logic [MOD_W-1:0] modulus_plan [8];
        int               sent;
        modulus_plan = '{8'd0, 8'd1, 8'd255, 8'd128, 8'd2, 8'd127, 8'd0, 8'd127};
        modulus_plan[4] = MOD_W'($urandom_range(1, 128));
        modulus_plan[6] = MOD_W'($urandom_range(0, 255));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme digits and tags, repeated home slot, overlong key
        send_digit(4'd0, 16'h0000, 1'b1);
        send_digit(4'd9, 16'hFFFF, 1'b1);
        send_digit(4'd15, 16'hA5A5, 1'b1);
        send_digit(4'd0, 16'h0001, 1'b1);
        send_digit(4'd0, 16'h0002, 1'b1);
        for (int i = 0; i < 20; i++)
            send_digit(4'd15, 16'h5A5A, i == 19);
        drain_results();

        // Random phases, one modulus setting each
        foreach (modulus_plan[p])
        begin
            write_modulus(modulus_plan[p]);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                send_random_key(sent);
                if ($urandom_range(0, 29) == 0)
                    drain_results();
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_total == 0 && inserts_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/qph_pkg.sv
rtl/qph_divider.sv
rtl/qph_table.sv
rtl/quadratic_probe_hash_insert_core.sv
sim/qph_insert_checker.sv
sim/tb_quadratic_probe_hash_insert_core.sv
